// File: hw/rtl/dmac_pkg.sv
// shared types, codes and helper functions of the six-channel dma controller
package dmac_pkg;

   // item kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // result kinds
   localparam logic [1:0] RES_READ = 2'd0;
   localparam logic [1:0] RES_DONE = 2'd1;
   localparam logic [1:0] RES_COPY = 2'd2;

   // register selects
   localparam logic [2:0] REG_SAR   = 3'd0;
   localparam logic [2:0] REG_DAR   = 3'd1;
   localparam logic [2:0] REG_TCR   = 3'd2;
   localparam logic [2:0] REG_CHCR  = 3'd3;
   localparam logic [2:0] REG_DMAOR = 3'd4;

   // write masks
   localparam logic [31:0] CHCR_KEEP_MASK  = 32'h0008_0002;
   localparam logic [31:0] CHCR_SET_MASK   = 32'h4fb7_fffd;
   localparam logic [15:0] DMAOR_KEEP_MASK = 16'h0006;
   localparam logic [15:0] DMAOR_SET_MASK  = 16'hf301;
   localparam logic [31:0] DE_CLEAR_MASK   = 32'hffff_fffe;

   // chcr bit positions
   localparam int CHCR_DE  = 0;
   localparam int CHCR_TE  = 1;
   localparam int CHCR_IE  = 2;
   localparam int CHCR_HIE = 18;
   localparam int CHCR_HE  = 19;

   localparam int IRQ_W = 6;

   // command passed from front to back
   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  channel;
      logic [2:0]  reg_select;
      logic [31:0] write_data;
      logic        ch_ok;
   } cmd_type;

   // one result item
   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] read_data;
      logic [2:0]  copy_channel;
      logic [31:0] copy_source;
      logic [31:0] copy_dest;
      logic [5:0]  copy_bytes;
      logic [5:0]  irq_lines;
      logic        last;
   } rsp_type;

   // transfer unit size from the combined ts code, zero when invalid
   function automatic logic [5:0] unit_bytes(input logic [3:0] ts);
      logic [5:0] b;
      unique case (ts)
         4'd0:    b = 6'd1;
         4'd1:    b = 6'd2;
         4'd2:    b = 6'd4;
         4'd3:    b = 6'd16;
         4'd4:    b = 6'd32;
         4'd7:    b = 6'd8;
         4'd11:   b = 6'd8;
         4'd12:   b = 6'd16;
         default: b = 6'd0;
      endcase
      return b;
   endfunction

   // address step: up for modes 0 and 1, down for 2, fixed for 3
   function automatic logic [31:0] next_addr(input logic [31:0] a, input logic [1:0] mode,
                                             input logic [5:0] bytes);
      logic [31:0] r;
      unique case (mode)
         2'd0, 2'd1: r = a + {26'd0, bytes};
         2'd2:       r = a - {26'd0, bytes};
         default:    r = a;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/dmac_if.sv
// request and response channel interfaces
interface dmac_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [2:0]  channel;
   logic [2:0]  reg_select;
   logic [31:0] write_data;
   modport source(output valid, kind, channel, reg_select, write_data, input ready);
   modport sink(input valid, kind, channel, reg_select, write_data, output ready);
endinterface

interface dmac_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [31:0] read_data;
   logic [2:0]  copy_channel;
   logic [31:0] copy_source;
   logic [31:0] copy_dest;
   logic [5:0]  copy_bytes;
   logic [5:0]  irq_lines;
   logic        last;
   modport source(output valid, result_kind, read_data, copy_channel, copy_source,
                  copy_dest, copy_bytes, irq_lines, last, input ready);
   modport sink(input valid, result_kind, read_data, copy_channel, copy_source,
                copy_dest, copy_bytes, irq_lines, last, output ready);
endinterface

// File: hw/rtl/dmac_front.sv
// request front end: classifies transfers and holds them in a two-entry queue
module dmac_front #(
   parameter int CHANNELS = 6
) (
   input  logic              clock,
   input  logic              reset,
   dmac_req_if.sink          req_chan,
   output logic              q_valid,
   output dmac_pkg::cmd_type q_cmd,
   input  logic              q_pop
);

   dmac_pkg::cmd_type entry_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic       push;
   dmac_pkg::cmd_type cls;

   // classify the incoming request
   always_comb begin
      cls.kind       = req_chan.kind;
      cls.channel    = req_chan.channel;
      cls.reg_select = req_chan.reg_select;
      cls.write_data = req_chan.write_data;
      cls.ch_ok      = ({1'b0, req_chan.channel} < 4'(CHANNELS));
   end

   assign req_chan.ready = (count_ff != 2'd2);
   assign push    = req_chan.valid && req_chan.ready;
   assign q_valid = (count_ff != 2'd0);
   assign q_cmd   = entry_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// File: hw/rtl/dmac_back.sv
// back end: register file, channel scan sequencer, copy buffer and result register
module dmac_back #(
   parameter int CHANNELS = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  dmac_pkg::cmd_type q_cmd,
   output logic              q_pop,
   dmac_rsp_if.source        rsp_chan
);

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int BUF_N = 2 * CHANNELS;
   localparam int IDX_W = $clog2(BUF_N);
   localparam int CNT_W = $clog2(BUF_N + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_FIN   = 2'd3;

   logic [31:0] sar_ff [CHANNELS];
   logic [31:0] sar_in [CHANNELS];
   logic [31:0] dar_ff [CHANNELS];
   logic [31:0] dar_in [CHANNELS];
   logic [31:0] tcr_ff [CHANNELS];
   logic [31:0] tcr_in [CHANNELS];
   logic [31:0] chcr_ff [CHANNELS];
   logic [31:0] chcr_in [CHANNELS];
   logic [31:0] stc_ff [CHANNELS];
   logic [31:0] stc_in [CHANNELS];
   logic [15:0] dmaor_ff, dmaor_in;

   logic [1:0]       state_ff, state_in;
   logic [CH_W-1:0]  scan_ff, scan_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, rd_ff, rd_in, cnt_next;

   logic [2:0]  buf_ch_ff [BUF_N];
   logic [31:0] buf_src_ff [BUF_N];
   logic [31:0] buf_dst_ff [BUF_N];
   logic [5:0]  buf_bytes_ff [BUF_N];
   logic        wr0, wr1;
   logic [31:0] w_src0, w_dst0, w_src1, w_dst1;
   logic [5:0]  w_bytes;

   logic                rsp_valid_ff, rsp_valid_in;
   dmac_pkg::rsp_type   rsp_ff, rsp_in;
   logic                out_free;
   logic [5:0]          irq_cur;

   logic [CH_W-1:0] ch_idx;
   logic [31:0] c_reg, s_reg, d_reg, t_reg, st_reg;
   logic [3:0]  ts;
   logic [1:0]  sm, dm;
   logic [5:0]  bytes;
   logic        split, bad;
   logic [31:0] s_mid, d_mid, s_end, d_end, t_dec, chcr_new;
   logic [31:0] dmaor_op;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign cnt_next = cnt_ff + CNT_W'(1);

   // interrupt levels from the current channel control words
   always_comb begin
      irq_cur = '0;
      for (int i = 0; i < dmac_pkg::IRQ_W; i++) begin
         if (i < CHANNELS) begin
            irq_cur[i] = (chcr_ff[i][dmac_pkg::CHCR_HE] && chcr_ff[i][dmac_pkg::CHCR_HIE]) ||
                         (chcr_ff[i][dmac_pkg::CHCR_TE] && chcr_ff[i][dmac_pkg::CHCR_IE]);
         end
      end
   end

   // selected channel registers
   assign ch_idx = (state_ff == ST_SCAN) ? scan_ff : q_cmd.channel[CH_W-1:0];
   assign c_reg  = chcr_ff[ch_idx];
   assign s_reg  = sar_ff[ch_idx];
   assign d_reg  = dar_ff[ch_idx];
   assign t_reg  = tcr_ff[ch_idx];
   assign st_reg = stc_ff[ch_idx];

   // transfer unit decode for the selected channel and masked register write values
   always_comb begin
      ts     = {c_reg[21:20], c_reg[4:3]};
      sm     = c_reg[13:12];
      dm     = c_reg[15:14];
      bytes  = dmac_pkg::unit_bytes(ts);
      split  = (ts == 4'd11) || (ts == 4'd12);
      bad    = (c_reg[27:25] != 3'd0) || (bytes == 6'd0) ||
               (((sm == 2'd2) || (dm == 2'd2)) && (bytes > 6'd4));
      s_mid  = dmac_pkg::next_addr(s_reg, sm, bytes);
      d_mid  = dmac_pkg::next_addr(d_reg, dm, bytes);
      s_end  = split ? dmac_pkg::next_addr(s_mid, sm, bytes) : s_mid;
      d_end  = split ? dmac_pkg::next_addr(d_mid, dm, bytes) : d_mid;
      t_dec  = t_reg - 32'd1;
      chcr_new = (c_reg & q_cmd.write_data & dmac_pkg::CHCR_KEEP_MASK) |
                 (q_cmd.write_data & dmac_pkg::CHCR_SET_MASK);
      dmaor_op = ({16'd0, dmaor_ff} & q_cmd.write_data & {16'd0, dmac_pkg::DMAOR_KEEP_MASK}) |
                 (q_cmd.write_data & {16'd0, dmac_pkg::DMAOR_SET_MASK});
   end

   // sequencer
   always_comb begin
      sar_in   = sar_ff;
      dar_in   = dar_ff;
      tcr_in   = tcr_ff;
      chcr_in  = chcr_ff;
      stc_in   = stc_ff;
      dmaor_in = dmaor_ff;
      state_in = state_ff;
      scan_in  = scan_ff;
      cnt_in   = cnt_ff;
      rd_in    = rd_ff;
      q_pop    = 1'b0;
      wr0      = 1'b0;
      wr1      = 1'b0;
      w_src0   = s_reg;
      w_dst0   = d_reg;
      w_src1   = s_mid;
      w_dst1   = d_mid;
      w_bytes  = bytes;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in   = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd.kind)
                  dmac_pkg::KIND_READ: begin
                     if (out_free) begin
                        q_pop = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_in = '0;
                        rsp_in.result_kind = dmac_pkg::RES_READ;
                        rsp_in.irq_lines = irq_cur;
                        rsp_in.last = 1'b1;
                        if (q_cmd.reg_select == dmac_pkg::REG_DMAOR) begin
                           rsp_in.read_data = {16'd0, dmaor_ff};
                        end else if (q_cmd.ch_ok) begin
                           priority case (q_cmd.reg_select)
                              dmac_pkg::REG_SAR:  rsp_in.read_data = s_reg;
                              dmac_pkg::REG_DAR:  rsp_in.read_data = d_reg;
                              dmac_pkg::REG_TCR:  rsp_in.read_data = t_reg;
                              dmac_pkg::REG_CHCR: rsp_in.read_data = c_reg;
                              default:            rsp_in.read_data = 32'd0;
                           endcase
                        end
                     end
                  end
                  dmac_pkg::KIND_WRITE: begin
                     q_pop    = 1'b1;
                     state_in = ST_FIN;
                     if (q_cmd.reg_select == dmac_pkg::REG_DMAOR) begin
                        dmaor_in = dmaor_op[15:0];
                        if (!dmaor_op[0]) begin
                           for (int i = 0; i < CHANNELS; i++) begin
                              chcr_in[i] = chcr_ff[i] & dmac_pkg::DE_CLEAR_MASK;
                           end
                        end
                     end else if (q_cmd.ch_ok) begin
                        priority case (q_cmd.reg_select)
                           dmac_pkg::REG_SAR: sar_in[ch_idx] = q_cmd.write_data;
                           dmac_pkg::REG_DAR: dar_in[ch_idx] = q_cmd.write_data;
                           dmac_pkg::REG_TCR: tcr_in[ch_idx] = q_cmd.write_data;
                           dmac_pkg::REG_CHCR: begin
                              chcr_in[ch_idx] = chcr_new;
                              if (!c_reg[dmac_pkg::CHCR_DE] && chcr_new[dmac_pkg::CHCR_DE]) begin
                                 stc_in[ch_idx] = t_reg;
                              end
                           end
                           default: ;
                        endcase
                     end
                  end
                  dmac_pkg::KIND_TICK: begin
                     q_pop = 1'b1;
                     if (dmaor_ff[0]) begin
                        state_in = ST_SCAN;
                        scan_in  = '0;
                        cnt_in   = '0;
                     end else begin
                        state_in = ST_FIN;
                     end
                  end
                  default: begin
                     q_pop    = 1'b1;
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // one channel per cycle
            if (c_reg[dmac_pkg::CHCR_DE] && (t_reg != 32'd0)) begin
               if (bad) begin
                  chcr_in[ch_idx] = c_reg & dmac_pkg::DE_CLEAR_MASK;
               end else begin
                  wr0 = 1'b1;
                  wr1 = split;
                  cnt_in = split ? (cnt_ff + CNT_W'(2)) : cnt_next;
                  if (sm != 2'd0) sar_in[ch_idx] = s_end;
                  if (dm != 2'd0) dar_in[ch_idx] = d_end;
                  tcr_in[ch_idx] = t_dec;
                  chcr_in[ch_idx] = c_reg |
                     {12'd0, (t_dec <= {1'b0, st_reg[31:1]}), 19'd0} |
                     {30'd0, (t_dec == 32'd0), 1'b0};
               end
            end
            if (scan_ff == CH_W'(CHANNELS - 1)) begin
               state_in = ST_DRAIN;
               rd_in    = '0;
            end else begin
               scan_in = scan_ff + CH_W'(1);
            end
         end
         ST_DRAIN: begin
            if (rd_ff == cnt_ff) begin
               state_in = ST_FIN;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.result_kind  = dmac_pkg::RES_COPY;
               rsp_in.copy_channel = buf_ch_ff[rd_ff[IDX_W-1:0]];
               rsp_in.copy_source  = buf_src_ff[rd_ff[IDX_W-1:0]];
               rsp_in.copy_dest    = buf_dst_ff[rd_ff[IDX_W-1:0]];
               rsp_in.copy_bytes   = buf_bytes_ff[rd_ff[IDX_W-1:0]];
               rsp_in.irq_lines    = irq_cur;
               rd_in = rd_ff + CNT_W'(1);
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.result_kind = dmac_pkg::RES_DONE;
               rsp_in.irq_lines   = irq_cur;
               rsp_in.last        = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and register file
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         cnt_ff       <= '0;
         rd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         dmaor_ff     <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            sar_ff[i]  <= '0;
            dar_ff[i]  <= '0;
            tcr_ff[i]  <= '0;
            chcr_ff[i] <= '0;
            stc_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         cnt_ff       <= cnt_in;
         rd_ff        <= rd_in;
         rsp_valid_ff <= rsp_valid_in;
         dmaor_ff     <= dmaor_in;
         sar_ff       <= sar_in;
         dar_ff       <= dar_in;
         tcr_ff       <= tcr_in;
         chcr_ff      <= chcr_in;
         stc_ff       <= stc_in;
      end
   end

   // result register payload and copy buffer
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (wr0) begin
         buf_ch_ff[cnt_ff[IDX_W-1:0]]    <= 3'(scan_ff);
         buf_src_ff[cnt_ff[IDX_W-1:0]]   <= w_src0;
         buf_dst_ff[cnt_ff[IDX_W-1:0]]   <= w_dst0;
         buf_bytes_ff[cnt_ff[IDX_W-1:0]] <= w_bytes;
      end
      if (wr1) begin
         buf_ch_ff[cnt_next[IDX_W-1:0]]    <= 3'(scan_ff);
         buf_src_ff[cnt_next[IDX_W-1:0]]   <= w_src1;
         buf_dst_ff[cnt_next[IDX_W-1:0]]   <= w_dst1;
         buf_bytes_ff[cnt_next[IDX_W-1:0]] <= w_bytes;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_kind  = rsp_ff.result_kind;
   assign rsp_chan.read_data    = rsp_ff.read_data;
   assign rsp_chan.copy_channel = rsp_ff.copy_channel;
   assign rsp_chan.copy_source  = rsp_ff.copy_source;
   assign rsp_chan.copy_dest    = rsp_ff.copy_dest;
   assign rsp_chan.copy_bytes   = rsp_ff.copy_bytes;
   assign rsp_chan.irq_lines    = rsp_ff.irq_lines;
   assign rsp_chan.last         = rsp_ff.last;

endmodule

// File: hw/rtl/six_channel_dma_controller_core.sv
// six-channel dma controller top level
//
//   channel    role     carries
//   req_chan   sink     register read, register write or transfer-cycle tick
//   rsp_chan   source   read reply, copy command or done, with irq levels
//
// a request is registered in the front queue before the back end sees it
// register read: reply registered from idle; register write: apply, then done
// tick with DME set: scan every channel, then the drain sends each copy command,
// closes, and done follows; with DME clear, or an unknown kind: done follows
// a two-entry queue lets requests arrive while the back end is busy
// synchronous active-high reset clears the control state and channel registers to zero
module six_channel_dma_controller_core #(
   parameter int CHANNELS = 6
) (
   input  logic       clock,
   input  logic       reset,
   dmac_req_if.sink   req_chan,
   dmac_rsp_if.source rsp_chan
);

   logic              q_valid;
   logic              q_pop;
   dmac_pkg::cmd_type q_cmd;

   // accept and classify
   dmac_front #(.CHANNELS(CHANNELS)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .q_pop   (q_pop)
   );

   // execute
   dmac_back #(.CHANNELS(CHANNELS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_cmd),
      .q_pop   (q_pop),
      .rsp_chan(rsp_chan)
   );

endmodule

// File: hw/rtl/dmac_checker.sv
// port-level checker for the dma controller top level
module dmac_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_result_kind,
   input logic [5:0]  rsp_copy_bytes,
   input logic [31:0] rsp_read_data,
   input logic        rsp_last
);

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind) && $stable(rsp_last))
      else $error("result changed while stalled");

   // a copy command is never the final result of its item
   a_copy_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == dmac_pkg::RES_COPY) |-> !rsp_last)
      else $error("copy command marked last");

   // copy commands carry a legal size
   a_copy_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == dmac_pkg::RES_COPY) |->
      (rsp_copy_bytes == 6'd1 || rsp_copy_bytes == 6'd2 || rsp_copy_bytes == 6'd4 ||
       rsp_copy_bytes == 6'd8 || rsp_copy_bytes == 6'd16 || rsp_copy_bytes == 6'd32))
      else $error("bad copy size");

   // read replies and done results close their item, done has no data
   a_reply_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind != dmac_pkg::RES_COPY) |-> rsp_last &&
      (rsp_result_kind == dmac_pkg::RES_READ || rsp_read_data == 32'd0))
      else $error("reply framing wrong");

endmodule

bind six_channel_dma_controller_core dmac_checker u_dmac_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_result_kind(rsp_chan.result_kind),
   .rsp_copy_bytes (rsp_chan.copy_bytes),
   .rsp_read_data  (rsp_chan.read_data),
   .rsp_last       (rsp_chan.last)
);

// File: dv/six_channel_dma_controller_core_tb.sv
// testbench for the six-channel dma controller: directed table then random traffic
module six_channel_dma_controller_core_tb;

   localparam int NCH = 6;
   localparam int NUM_RANDOM = 450;
   localparam longint CYCLE_LIMIT = 2_000_000;
   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam logic [2:0] REG_NONE  = 3'd6;

   logic clock;
   logic reset;

   dmac_req_if req_chan ();
   dmac_rsp_if rsp_chan ();

   six_channel_dma_controller_core #(.CHANNELS(NCH)) u_top (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   // stimulus row; has_exp marks rows with a typed-in single result
   typedef struct {
      logic [1:0]  kind;
      logic [2:0]  channel;
      logic [2:0]  reg_select;
      logic [31:0] write_data;
      bit          has_exp;
      logic [31:0] exp_data;
   } stim_row_type;

   // predictor state
   logic [31:0] sar_q [NCH];
   logic [31:0] dar_q [NCH];
   logic [31:0] tcr_q [NCH];
   logic [31:0] chcr_q [NCH];
   logic [31:0] start_q [NCH];
   logic [15:0] dmaor_q;

   dmac_pkg::rsp_type expected_rsps [$];
   int send_idle_pct, recv_stall_pct;
   int errors, mismatches, rsp_count, copy_count, item_count;
   longint cycles;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // cycle watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [5:0] irq_now();
      logic [5:0] l;
      l = '0;
      for (int i = 0; i < NCH; i++)
         l[i] = (chcr_q[i][dmac_pkg::CHCR_HE] & chcr_q[i][dmac_pkg::CHCR_HIE]) |
                (chcr_q[i][dmac_pkg::CHCR_TE] & chcr_q[i][dmac_pkg::CHCR_IE]);
      return l;
   endfunction

   function automatic logic [5:0] size_of(input logic [3:0] ts);
      logic [5:0] b;
      case (ts)
         4'd0: b = 6'd1;
         4'd1: b = 6'd2;
         4'd2: b = 6'd4;
         4'd3: b = 6'd16;
         4'd4: b = 6'd32;
         4'd7, 4'd11: b = 6'd8;
         4'd12: b = 6'd16;
         default: b = 6'd0;
      endcase
      return b;
   endfunction

   function automatic logic [31:0] step_addr(input logic [31:0] a, input logic [1:0] m,
                                             input logic [5:0] b);
      if (m <= 1) return a + {26'd0, b};
      if (m == 2) return a - {26'd0, b};
      return a;
   endfunction

   // predict results of one dma item and queue them
   task automatic predict_dma_item(input logic [1:0] kind, input logic [2:0] ch,
                                   input logic [2:0] sel, input logic [31:0] v);
      dmac_pkg::rsp_type r;
      dmac_pkg::rsp_type batch [$];
      logic [31:0] c, nw, s, d;
      logic [3:0] ts;
      logic [1:0] sm, dm;
      logic [5:0] b;
      int parts;
      r = '0;
      if (kind == dmac_pkg::KIND_READ) begin
         r.result_kind = dmac_pkg::RES_READ;
         if (sel == dmac_pkg::REG_DMAOR) r.read_data = {16'd0, dmaor_q};
         else if (ch < NCH) begin
            case (sel)
               dmac_pkg::REG_SAR:  r.read_data = sar_q[ch];
               dmac_pkg::REG_DAR:  r.read_data = dar_q[ch];
               dmac_pkg::REG_TCR:  r.read_data = tcr_q[ch];
               dmac_pkg::REG_CHCR: r.read_data = chcr_q[ch];
               default:  r.read_data = 0;
            endcase
         end
         batch.push_back(r);
      end else if (kind == dmac_pkg::KIND_WRITE) begin
         if (sel == dmac_pkg::REG_DMAOR) begin
            dmaor_q = (dmaor_q & v[15:0] & dmac_pkg::DMAOR_KEEP_MASK) |
                      (v[15:0] & dmac_pkg::DMAOR_SET_MASK);
            if (!dmaor_q[0])
               for (int i = 0; i < NCH; i++) chcr_q[i][dmac_pkg::CHCR_DE] = 1'b0;
         end else if (ch < NCH) begin
            case (sel)
               dmac_pkg::REG_SAR: sar_q[ch] = v;
               dmac_pkg::REG_DAR: dar_q[ch] = v;
               dmac_pkg::REG_TCR: tcr_q[ch] = v;
               dmac_pkg::REG_CHCR: begin
                  nw = (chcr_q[ch] & v & dmac_pkg::CHCR_KEEP_MASK) |
                       (v & dmac_pkg::CHCR_SET_MASK);
                  if (!chcr_q[ch][dmac_pkg::CHCR_DE] && nw[dmac_pkg::CHCR_DE])
                     start_q[ch] = tcr_q[ch];
                  chcr_q[ch] = nw;
               end
               default: ;
            endcase
         end
         r.result_kind = dmac_pkg::RES_DONE;
         batch.push_back(r);
      end else begin
         // tick or unknown kind: a tick with DME set scans channels in ascending order
         if (kind == dmac_pkg::KIND_TICK && dmaor_q[0]) begin
            for (int i = 0; i < NCH; i++) begin
               c = chcr_q[i];
               if (!c[dmac_pkg::CHCR_DE] || tcr_q[i] == 0) continue;
               ts = {c[21:20], c[4:3]};
               sm = c[13:12];
               dm = c[15:14];
               b = size_of(ts);
               parts = (ts == 11 || ts == 12) ? 2 : 1;
               if (c[27:25] != 0 || b == 0 || ((sm == 2 || dm == 2) && b > 4)) begin
                  chcr_q[i] = c & dmac_pkg::DE_CLEAR_MASK;
                  continue;
               end
               s = sar_q[i];
               d = dar_q[i];
               for (int j = 0; j < parts; j++) begin
                  r = '0;
                  r.result_kind = dmac_pkg::RES_COPY;
                  r.copy_channel = 3'(i);
                  r.copy_source = s;
                  r.copy_dest = d;
                  r.copy_bytes = b;
                  batch.push_back(r);
                  s = step_addr(s, sm, b);
                  d = step_addr(d, dm, b);
               end
               if (sm != 0) sar_q[i] = s;
               if (dm != 0) dar_q[i] = d;
               tcr_q[i] = tcr_q[i] - 32'd1;
               if (tcr_q[i] <= (start_q[i] >> 1)) chcr_q[i][dmac_pkg::CHCR_HE] = 1'b1;
               if (tcr_q[i] == 0) chcr_q[i][dmac_pkg::CHCR_TE] = 1'b1;
            end
         end
         r = '0;
         r.result_kind = dmac_pkg::RES_DONE;
         batch.push_back(r);
      end
      foreach (batch[k]) begin
         batch[k].irq_lines = irq_now();
         batch[k].last = (k == batch.size() - 1);
         expected_rsps.push_back(batch[k]);
      end
   endtask

   // send one item, waiting for the transfer; valid stays up for a following item
   task automatic send_item(input logic [1:0] kind, input logic [2:0] ch,
                            input logic [2:0] sel, input logic [31:0] v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.kind <= kind;
      req_chan.channel <= ch;
      req_chan.reg_select <= sel;
      req_chan.write_data <= v;
      predict_dma_item(kind, ch, sel, v);
      item_count++;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // response side: random stall and compare
   always @(posedge clock) begin
      dmac_pkg::rsp_type got, want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.result_kind = rsp_chan.result_kind;
            got.read_data = rsp_chan.read_data;
            got.copy_channel = rsp_chan.copy_channel;
            got.copy_source = rsp_chan.copy_source;
            got.copy_dest = rsp_chan.copy_dest;
            got.copy_bytes = rsp_chan.copy_bytes;
            got.irq_lines = rsp_chan.irq_lines;
            got.last = rsp_chan.last;
            rsp_count++;
            if (got.result_kind == dmac_pkg::RES_COPY) copy_count++;
            if (expected_rsps.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("unexpected response %p", got);
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  errors++;
                  if (mismatches++ < 10) $display("mismatch exp %p got %p", want, got);
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // random item: mostly well-formed channel setups and ticks
   task automatic random_item();
      int p;
      logic [2:0] ch;
      logic [31:0] v;
      p = $urandom_range(99);
      ch = 3'($urandom_range(7));
      v = $urandom;
      if (p < 35) begin
         send_item(dmac_pkg::KIND_TICK, ch, 3'($urandom_range(7)), v);
      end else if (p < 45) begin
         send_item(dmac_pkg::KIND_READ, ch, 3'($urandom_range(7)), v);
      end else if (p < 55) begin
         send_item(dmac_pkg::KIND_WRITE, ch, dmac_pkg::REG_SAR + 3'($urandom_range(1)), v);
      end else if (p < 65) begin
         send_item(dmac_pkg::KIND_WRITE, ch, dmac_pkg::REG_TCR, $urandom_range(6));
      end else if (p < 80) begin
         // legal-ish chcr: no repeat, mostly DE set
         v = v & ~32'h0e00_0000;
         if ($urandom_range(3) != 0) v[0] = 1'b1;
         if ($urandom_range(1)) v[21:20] = 2'd0;
         send_item(dmac_pkg::KIND_WRITE, ch, dmac_pkg::REG_CHCR, v);
      end else if (p < 88) begin
         if ($urandom_range(4) != 0) v[0] = 1'b1;
         send_item(dmac_pkg::KIND_WRITE, ch, dmac_pkg::REG_DMAOR, v);
      end else if (p < 92) begin
         send_item(KIND_NONE, ch, 3'($urandom_range(7)), v);
      end else begin
         send_item(dmac_pkg::KIND_WRITE, ch, 3'($urandom_range(7)), v);
      end
   endtask

   stim_row_type directed_rows [$];
   stim_row_type row;

   function automatic stim_row_type mk(input logic [1:0] k, input logic [2:0] c,
                                       input logic [2:0] s, input logic [31:0] v,
                                       input bit he, input logic [31:0] ed);
      stim_row_type t;
      t.kind = k; t.channel = c; t.reg_select = s; t.write_data = v;
      t.has_exp = he; t.exp_data = ed;
      return t;
   endfunction

   initial begin
      errors = 0; mismatches = 0; rsp_count = 0; copy_count = 0; item_count = 0;
      cycles = 0;
      send_idle_pct = 0; recv_stall_pct = 0;
      for (int i = 0; i < NCH; i++) begin
         sar_q[i] = 0; dar_q[i] = 0; tcr_q[i] = 0; chcr_q[i] = 0; start_q[i] = 0;
      end
      dmaor_q = 0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.kind = dmac_pkg::KIND_READ;
      req_chan.channel = 0;
      req_chan.reg_select = dmac_pkg::REG_SAR;
      req_chan.write_data = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      directed_rows = '{
         mk(dmac_pkg::KIND_READ, 0, dmac_pkg::REG_SAR, 0, 1, 0),
         mk(dmac_pkg::KIND_READ, 3, dmac_pkg::REG_DMAOR, 0, 1, 0),
         mk(dmac_pkg::KIND_WRITE, 0, dmac_pkg::REG_SAR, 32'hffff_ffff, 0, 0),
         mk(dmac_pkg::KIND_READ, 0, dmac_pkg::REG_SAR, 0, 1, 32'hffff_ffff),
         mk(dmac_pkg::KIND_WRITE, 0, dmac_pkg::REG_DAR, 32'h0000_0010, 0, 0),
         mk(dmac_pkg::KIND_WRITE, 0, dmac_pkg::REG_TCR, 32'd4, 0, 0),
         mk(dmac_pkg::KIND_WRITE, 0, dmac_pkg::REG_CHCR, 32'h000c_5005, 0, 0),
         mk(dmac_pkg::KIND_WRITE, 7, dmac_pkg::REG_SAR, 32'h1234, 0, 0),
         mk(dmac_pkg::KIND_READ, 7, dmac_pkg::REG_SAR, 0, 1, 0),
         mk(dmac_pkg::KIND_READ, 0, REG_NONE, 0, 1, 0),
         mk(dmac_pkg::KIND_WRITE, 0, dmac_pkg::REG_DMAOR, 32'hffff_ffff, 0, 0),
         mk(dmac_pkg::KIND_READ, 0, dmac_pkg::REG_DMAOR, 0, 1, 32'h0000_f301),
         mk(dmac_pkg::KIND_WRITE, 1, dmac_pkg::REG_TCR, 32'd3, 0, 0),
         mk(dmac_pkg::KIND_WRITE, 1, dmac_pkg::REG_CHCR, 32'h0010_1019, 0, 0),
         mk(dmac_pkg::KIND_WRITE, 2, dmac_pkg::REG_TCR, 32'd2, 0, 0),
         mk(dmac_pkg::KIND_WRITE, 2, dmac_pkg::REG_CHCR, 32'h0000_8011, 0, 0),
         mk(dmac_pkg::KIND_WRITE, 3, dmac_pkg::REG_TCR, 32'd2, 0, 0),
         mk(dmac_pkg::KIND_WRITE, 3, dmac_pkg::REG_CHCR, 32'h0200_0001, 0, 0),
         mk(dmac_pkg::KIND_WRITE, 4, dmac_pkg::REG_TCR, 32'd1, 0, 0),
         mk(dmac_pkg::KIND_WRITE, 4, dmac_pkg::REG_CHCR, 32'h0020_f007, 0, 0),
         mk(dmac_pkg::KIND_TICK, 0, dmac_pkg::REG_SAR, 0, 0, 0),
         mk(dmac_pkg::KIND_TICK, 0, dmac_pkg::REG_SAR, 0, 0, 0),
         mk(KIND_NONE, 0, dmac_pkg::REG_SAR, 0, 0, 0),
         mk(dmac_pkg::KIND_WRITE, 0, dmac_pkg::REG_DMAOR, 32'h0, 0, 0),
         mk(dmac_pkg::KIND_READ, 0, dmac_pkg::REG_CHCR, 0, 0, 0)
      };
      recv_stall_pct = 20;
      for (int n = 0; n < directed_rows.size(); n++) begin
         row = directed_rows[n];
         if (row.has_exp) begin
            // typed-in reply replaces the predicted read data
            send_item(row.kind, row.channel, row.reg_select, row.write_data);
            expected_rsps[expected_rsps.size() - 1].read_data = row.exp_data;
         end else begin
            send_item(row.kind, row.channel, row.reg_select, row.write_data);
         end
      end
      drain();

      // random phases with different idle patterns
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            3: begin send_idle_pct = 31; recv_stall_pct = 31; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         for (int n = 0; n < NUM_RANDOM / 5; n++) random_item();
         drain();
      end

      $display("sent %0d items, checked %0d responses including %0d copy commands",
               item_count, rsp_count, copy_count);
      $display("idle patterns: none, sender idle, receiver stall, both");
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d responses outstanding", errors,
                  expected_rsps.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
